// ===== src/generational_handle_table_unit_macros.svh =====
// Assertion macros shared by the handle table checker.
// Each macro expects signals named clk and rst in the scope of use.
`ifndef GENERATIONAL_HANDLE_TABLE_UNIT_MACROS_SVH
`define GENERATIONAL_HANDLE_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define GHT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define GHT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/ght_pkg.sv =====
// Shared types and codes for the generational handle table.
// No dependencies; imported by the controller, datapath, top level and checker.
package ght_pkg;

  // Operation codes carried on mode.
  localparam logic [1:0] MODE_ALLOC   = 2'd0;
  localparam logic [1:0] MODE_LOOKUP  = 2'd1;
  localparam logic [1:0] MODE_DESTROY = 2'd2;

  // Result status codes.
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_MISS = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned COUNT_W = 8;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } ght_state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;   // capture the transaction and launch memory reads
    logic exec;   // resolve the operation, write memories, load results
  } ght_cmd_t;

endpackage

// ===== src/ght_ctrl.sv =====
// Sequencer for the handle table: accepts a transaction, runs one execute step.
// Depends on ght_pkg.
module ght_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  output logic            done,
  output ght_pkg::ght_cmd_t cmd
);
  import ght_pkg::*;

  ght_state_t state;
  ght_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.exec;
    end
  end

  always_comb begin
    state_next = state;
    cmd.load   = 1'b0;
    cmd.exec   = 1'b0;
    busy       = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        busy       = 1'b1;
        cmd.exec   = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== src/ght_dp.sv =====
// Datapath for the handle table: slot memory, recycle queue memory, counters.
// Depends on ght_pkg; driven by ght_ctrl commands.
module ght_dp #(
  parameter int SLOT_BITS   = 8,
  parameter int MAX_SLOTS   = 256,
  parameter int HANDLE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  ght_pkg::ght_cmd_t            cmd,
  input  logic [1:0]                   mode,
  input  logic [31:0]                  handle,
  input  logic [ght_pkg::DATA_W-1:0]   entry_data,
  output logic [1:0]                   status,
  output logic [31:0]                  handle_out,
  output logic [ght_pkg::DATA_W-1:0]   entry_data_out,
  output logic [ght_pkg::COUNT_W-1:0]  live_count
);
  import ght_pkg::*;

  localparam int DEPTH = 1 << SLOT_BITS;
  localparam int BW    = SLOT_BITS + 1;
  localparam int CW    = (HANDLE_BITS > 32) ? HANDLE_BITS : 32;
  localparam int EW    = 1 + HANDLE_BITS + DATA_W;
  localparam int CMAX  = (1 << COUNT_W) - 1;

  // Slot entry: {used, stored handle, tag}.
  logic [EW-1:0]          slot_mem [DEPTH];
  logic [HANDLE_BITS-1:0] fifo_mem [DEPTH];

  logic [BW-1:0]          bound;
  logic [BW-1:0]          bound_next;
  logic [SLOT_BITS-1:0]   head;
  logic [SLOT_BITS-1:0]   head_next;
  logic [SLOT_BITS-1:0]   tail;
  logic [SLOT_BITS-1:0]   tail_next;
  logic [BW-1:0]          fill;
  logic [BW-1:0]          fill_next;
  logic [BW-1:0]          live;
  logic [BW-1:0]          live_next;

  logic [1:0]             mode_q;
  logic [31:0]            handle_q;
  logic [DATA_W-1:0]      data_q;
  logic [EW-1:0]          slot_rd;
  logic [HANDLE_BITS-1:0] fifo_rd;

  logic                   rd_used;
  logic [HANDLE_BITS-1:0] rd_handle;
  logic [DATA_W-1:0]      rd_data;
  logic [SLOT_BITS-1:0]   idx_q;
  logic                   found;
  logic                   have_fifo;
  logic                   fresh_ok;
  logic [HANDLE_BITS-1:0] new_handle;

  logic                   slot_we;
  logic [SLOT_BITS-1:0]   slot_waddr;
  logic [EW-1:0]          slot_wdata;
  logic                   fifo_we;
  logic [HANDLE_BITS-1:0] fifo_wdata;

  logic [1:0]             status_next;
  logic [31:0]            hout_next;
  logic [DATA_W-1:0]      dout_next;

  assign rd_used   = slot_rd[EW-1];
  assign rd_handle = slot_rd[EW-2:DATA_W];
  assign rd_data   = slot_rd[DATA_W-1:0];
  assign idx_q     = handle_q[SLOT_BITS-1:0];

  // Slots below the fresh bound were all written at allocation; slot 0 never is.
  assign found = (idx_q != '0) && (BW'(idx_q) < bound) && rd_used &&
                 (CW'(rd_handle) == CW'(handle_q));

  assign have_fifo  = (fill != '0);
  assign fresh_ok   = (32'(bound) < 32'(MAX_SLOTS)) && (32'(bound) < 32'(DEPTH));
  assign new_handle = have_fifo ? fifo_rd : HANDLE_BITS'(bound);

  always_comb begin
    bound_next  = bound;
    head_next   = head;
    tail_next   = tail;
    fill_next   = fill;
    live_next   = live;
    slot_we     = 1'b0;
    slot_waddr  = idx_q;
    slot_wdata  = {1'b0, rd_handle, rd_data};
    fifo_we     = 1'b0;
    fifo_wdata  = rd_handle + HANDLE_BITS'(DEPTH);
    status_next = STAT_MISS;
    hout_next   = handle_q;
    dout_next   = '0;
    case (mode_q)
      MODE_ALLOC: begin
        if (have_fifo || fresh_ok) begin
          slot_we     = 1'b1;
          slot_waddr  = new_handle[SLOT_BITS-1:0];
          slot_wdata  = {1'b1, new_handle, data_q};
          live_next   = live + BW'(1);
          status_next = STAT_OK;
          hout_next   = 32'(new_handle);
          if (have_fifo) begin
            head_next = head + SLOT_BITS'(1);
            fill_next = fill - BW'(1);
          end else begin
            bound_next = bound + BW'(1);
          end
        end else begin
          status_next = STAT_FULL;
        end
      end
      MODE_LOOKUP: begin
        if (found) begin
          status_next = STAT_OK;
          dout_next   = rd_data;
        end
      end
      MODE_DESTROY: begin
        if (found) begin
          status_next = STAT_OK;
          dout_next   = rd_data;
          slot_we     = 1'b1;
          if (live != '0) begin
            live_next = live - BW'(1);
          end
          if (32'(fill) < 32'(DEPTH)) begin
            fifo_we   = 1'b1;
            tail_next = tail + SLOT_BITS'(1);
            fill_next = fill + BW'(1);
          end
        end
      end
      default: begin
        status_next = STAT_MISS;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bound <= BW'(1);
      head  <= '0;
      tail  <= '0;
      fill  <= '0;
      live  <= '0;
    end else if (cmd.exec) begin
      bound <= bound_next;
      head  <= head_next;
      tail  <= tail_next;
      fill  <= fill_next;
      live  <= live_next;
    end
  end

  // Capture the transaction and read both memories.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q   <= mode;
      handle_q <= handle;
      data_q   <= entry_data;
      slot_rd  <= slot_mem[handle[SLOT_BITS-1:0]];
      fifo_rd  <= fifo_mem[head];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    if (cmd.exec && fifo_we) begin
      fifo_mem[tail] <= fifo_wdata;
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status         <= status_next;
      handle_out     <= hout_next;
      entry_data_out <= dout_next;
      live_count     <= (32'(live_next) > 32'(CMAX)) ? COUNT_W'(CMAX)
                                                     : COUNT_W'(live_next);
    end
  end

endmodule

// ===== src/generational_handle_table_unit.sv =====
// Generational handle table: allocate, look up and destroy handles.
// A transaction is captured together with the registered read of the slot and
// queue memories, then resolved in the execute step; done comes high with the
// registered result. Busy is high in the execute step, and no start is taken then.
// Reset (rst, synchronous) frees all slots and empties the recycle queue; the
// receiver cannot stall; done is high for one cycle only, and the result stays until the next one.
module generational_handle_table_unit #(
  parameter int SLOT_BITS   = 8,
  parameter int MAX_SLOTS   = 256,
  parameter int HANDLE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   mode,
  input  logic [31:0]                  handle,
  input  logic [ght_pkg::DATA_W-1:0]   entry_data,
  output logic                         done,
  output logic [1:0]                   status,
  output logic [31:0]                  handle_out,
  output logic [ght_pkg::DATA_W-1:0]   entry_data_out,
  output logic [ght_pkg::COUNT_W-1:0]  live_count
);
  import ght_pkg::*;

  // Commands from the sequencer: load in the accept cycle, exec in the cycle after.
  ght_cmd_t cmd;

  // Sequencer: hold busy for the execute step, then pulse done with the result.
  ght_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  // Datapath: slot entries carry {used, handle, tag}. A slot index at or above
  // the fresh bound was never written, so the bound check stands in for a
  // cleared used flag; slot 0 is never handed out and always misses.
  // Destroy advances the generation by adding DEPTH, keeping the slot index, and queues the
  // handle; allocate drains that queue before taking a fresh slot.
  ght_dp #(
    .SLOT_BITS   (SLOT_BITS),
    .MAX_SLOTS   (MAX_SLOTS),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .mode           (mode),
    .handle         (handle),
    .entry_data     (entry_data),
    .status         (status),
    .handle_out     (handle_out),
    .entry_data_out (entry_data_out),
    .live_count     (live_count)
  );

endmodule

// ===== src/ght_checker.sv =====
// Port-level checker for the handle table, bound to the top level.
// Depends on ght_pkg and generational_handle_table_unit_macros.svh.
`include "generational_handle_table_unit_macros.svh"

module ght_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         start,
  input logic                         busy,
  input logic [1:0]                   mode,
  input logic                         done,
  input logic [1:0]                   status
);
  import ght_pkg::*;

  `GHT_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done, "accept did not raise busy")
  `GHT_ASSERT_NEXT(a_busy_done, busy, done && !busy, "execute step did not produce a result")
  `GHT_ASSERT_NOW(a_done_origin, done, $past(start && !busy, 2), "result without transaction")
  `GHT_ASSERT_NOW(a_full_alloc, done && (status == STAT_FULL), $past(mode, 2) == MODE_ALLOC, "full status on non-allocate")
  `GHT_ASSERT_NOW(a_status_code, done, status != 2'd3, "undefined status code")

endmodule

bind generational_handle_table_unit ght_checker u_ght_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .mode   (mode),
  .done   (done),
  .status (status)
);
